// ===== hw/rtl/rhsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared constants and types for the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

	localparam int HUE_FRAC_BITS_DEF = 6;
	localparam int SAT_BITS_DEF      = 16;

	localparam int PIX_W  = 24;
	localparam int CH_W   = 8;
	localparam int HUE_W  = 15;
	localparam int SAT_W  = 16;
	localparam int VAL_W  = 8;
	localparam int DEN_W  = CH_W + 1;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;

	// Which channel holds the maximum; selects the hue sextant base.
	typedef enum logic [1:0] {
		SEXT_RED   = 2'd0,
		SEXT_GREEN = 2'd1,
		SEXT_BLUE  = 2'd2
	} sextant_t;

	// Per-pixel information that rides alongside the dividers.
	typedef struct packed {
		logic            neg;
		sextant_t        sext;
		logic            delta_nz;
		logic            max_nz;
		logic [CH_W-1:0] max;
	} hsv_side_t;

endpackage

// ===== hw/rtl/rhsv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_front
// Two pipeline stages: channel compare and selection, then dividend forming.
// ----------------------------------------------------------------------------
module rhsv_front import rhsv_pkg::*; #(
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
	parameter int SAT_BITS      = SAT_BITS_DEF,
	parameter int HUE_NUM_W     = 22,
	parameter int SAT_NUM_W     = SAT_BITS_DEF + 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [PIX_W-1:0]     pixel_rgb,
	output logic                 out_valid,
	output logic [HUE_NUM_W-1:0] hue_num,
	output logic [DEN_W-1:0]     hue_den,
	output logic [SAT_NUM_W-1:0] sat_num,
	output logic [DEN_W-1:0]     sat_den,
	output hsv_side_t            side
);

	localparam int HUE_SEXTANT = 60 << HUE_FRAC_BITS;

	logic [CH_W-1:0]     red, green, blue;
	logic [CH_W-1:0]     mx, mn;
	logic signed [CH_W:0] diff;
	sextant_t            sext;

	logic                v_s1;
	logic [CH_W-1:0]     mag_s1, delta_s1, max_s1;
	logic                neg_s1;
	sextant_t            sext_s1;

	logic                v_s2;
	logic [HUE_NUM_W-1:0] hue_num_s2;
	logic [DEN_W-1:0]     hue_den_s2;
	logic [SAT_NUM_W-1:0] sat_num_s2;
	logic [DEN_W-1:0]     sat_den_s2;
	hsv_side_t            side_s2;

	assign red   = pixel_rgb[23:16];
	assign green = pixel_rgb[15:8];
	assign blue  = pixel_rgb[7:0];

	// Ties for the maximum go to red first, then green.
	always_comb begin
		if (red >= green && red >= blue) begin
			sext = SEXT_RED;
			mx   = red;
			diff = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green >= blue) begin
			sext = SEXT_GREEN;
			mx   = green;
			diff = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sext = SEXT_BLUE;
			mx   = blue;
			diff = $signed({1'b0, red}) - $signed({1'b0, green});
		end
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1   <= diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
			neg_s1   <= diff[CH_W];
			delta_s1 <= mx - mn;
			max_s1   <= mx;
			sext_s1  <= sext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	// Rounded quotients are floor((2*a + b) / (2*b)).
	always_ff @(posedge clk) begin
		if (en) begin
			hue_num_s2 <= HUE_NUM_W'(mag_s1) * HUE_NUM_W'(2 * HUE_SEXTANT)
				+ HUE_NUM_W'(delta_s1);
			hue_den_s2 <= {delta_s1, 1'b0};
			sat_num_s2 <= (SAT_NUM_W'(delta_s1) << (SAT_BITS + 1))
				- SAT_NUM_W'({delta_s1, 1'b0}) + SAT_NUM_W'(max_s1);
			sat_den_s2 <= {max_s1, 1'b0};
			side_s2.neg      <= neg_s1;
			side_s2.sext     <= sext_s1;
			side_s2.delta_nz <= (delta_s1 != '0);
			side_s2.max_nz   <= (max_s1 != '0);
			side_s2.max      <= max_s1;
		end
	end

	assign out_valid = v_s2;
	assign hue_num   = hue_num_s2;
	assign hue_den   = hue_den_s2;
	assign sat_num   = sat_num_s2;
	assign sat_den   = sat_den_s2;
	assign side      = side_s2;

endmodule

// ===== hw/rtl/rhsv_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_div
// Pipelined restoring divider pair: one quotient bit per stage for hue and
// saturation side by side.
// ----------------------------------------------------------------------------
module rhsv_div import rhsv_pkg::*; #(
	parameter int HUE_NUM_W = 22,
	parameter int SAT_NUM_W = SAT_BITS_DEF + 9,
	parameter int QUO_W     = SAT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [HUE_NUM_W-1:0] hue_num,
	input  logic [DEN_W-1:0]     hue_den,
	input  logic [SAT_NUM_W-1:0] sat_num,
	input  logic [DEN_W-1:0]     sat_den,
	input  hsv_side_t            side_in,
	output logic                 out_valid,
	output logic [QUO_W-1:0]     hue_quo,
	output logic [QUO_W-1:0]     sat_quo,
	output hsv_side_t            side_out
);

	localparam int HUE_REM_W = (HUE_NUM_W > DEN_W + QUO_W) ? HUE_NUM_W : DEN_W + QUO_W;
	localparam int SAT_REM_W = (SAT_NUM_W > DEN_W + QUO_W) ? SAT_NUM_W : DEN_W + QUO_W;

	// Element 0 is the stage input; element k holds the result of stage k.
	logic                 v_s       [0:QUO_W];
	logic [HUE_REM_W-1:0] hue_rem_s [0:QUO_W];
	logic [SAT_REM_W-1:0] sat_rem_s [0:QUO_W];
	logic [DEN_W-1:0]     hue_den_s [0:QUO_W];
	logic [DEN_W-1:0]     sat_den_s [0:QUO_W];
	logic [QUO_W-1:0]     hue_quo_s [0:QUO_W];
	logic [QUO_W-1:0]     sat_quo_s [0:QUO_W];
	hsv_side_t            side_s    [0:QUO_W];

	assign v_s[0]       = in_valid;
	assign hue_rem_s[0] = HUE_REM_W'(hue_num);
	assign sat_rem_s[0] = SAT_REM_W'(sat_num);
	assign hue_den_s[0] = hue_den;
	assign sat_den_s[0] = sat_den;
	assign hue_quo_s[0] = '0;
	assign sat_quo_s[0] = '0;
	assign side_s[0]    = side_in;

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		// Stage k decides quotient bit QUO_W-1-k.
		localparam int SH = QUO_W - 1 - k;

		logic [HUE_REM_W-1:0] hue_trial;
		logic [SAT_REM_W-1:0] sat_trial;
		logic                 hue_ge, sat_ge;

		assign hue_trial = HUE_REM_W'(hue_den_s[k]) << SH;
		assign sat_trial = SAT_REM_W'(sat_den_s[k]) << SH;
		assign hue_ge    = (hue_rem_s[k] >= hue_trial);
		assign sat_ge    = (sat_rem_s[k] >= sat_trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hue_rem_s[k+1] <= hue_ge ? hue_rem_s[k] - hue_trial : hue_rem_s[k];
				sat_rem_s[k+1] <= sat_ge ? sat_rem_s[k] - sat_trial : sat_rem_s[k];
				hue_quo_s[k+1] <= {hue_quo_s[k][QUO_W-2:0], hue_ge};
				sat_quo_s[k+1] <= {sat_quo_s[k][QUO_W-2:0], sat_ge};
				hue_den_s[k+1] <= hue_den_s[k];
				sat_den_s[k+1] <= sat_den_s[k];
				side_s[k+1]    <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[QUO_W];
	assign hue_quo   = hue_quo_s[QUO_W];
	assign sat_quo   = sat_quo_s[QUO_W];
	assign side_out  = side_s[QUO_W];

endmodule

// ===== hw/rtl/rhsv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_back
// Final stage: hue assembly with wrap, special cases, output register.
// ----------------------------------------------------------------------------
module rhsv_back import rhsv_pkg::*; #(
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
	parameter int QUO_W         = SAT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [QUO_W-1:0] hue_quo,
	input  logic [QUO_W-1:0] sat_quo,
	input  hsv_side_t        side,
	output logic             out_valid,
	output logic [HUE_W-1:0] hue,
	output logic [SAT_W-1:0] saturation,
	output logic [VAL_W-1:0] brightness
);

	localparam int HUE_SEXTANT = 60 << HUE_FRAC_BITS;
	localparam int HUE_FULL    = 360 << HUE_FRAC_BITS;
	localparam int HQ_W        = $clog2(HUE_SEXTANT + 1);
	localparam int HB_W        = $clog2(HUE_FULL) + 2;

	logic signed [HB_W-1:0]  base, offset, raw, wrapped;
	logic [HB_W+HUE_W-1:0]   hue_ext;
	logic [QUO_W+SAT_W-1:0]  sat_ext;

	logic                    v_q;
	logic [HUE_W-1:0]        hue_q;
	logic [SAT_W-1:0]        sat_q;
	logic [VAL_W-1:0]        val_q;

	always_comb begin
		case (side.sext)
			SEXT_RED:   base = '0;
			SEXT_GREEN: base = $signed(HB_W'(2 * HUE_SEXTANT));
			SEXT_BLUE:  base = $signed(HB_W'(4 * HUE_SEXTANT));
			default:    base = '0;
		endcase
		offset = $signed(HB_W'(hue_quo[HQ_W-1:0]));
		if (side.neg) offset = -offset;
		raw = base + offset;
		if (raw[HB_W-1]) begin
			wrapped = raw + $signed(HB_W'(HUE_FULL));
		end else if (raw >= $signed(HB_W'(HUE_FULL))) begin
			wrapped = raw - $signed(HB_W'(HUE_FULL));
		end else begin
			wrapped = raw;
		end
		// A grey pixel has no defined hue; it reads as zero.
		if (!side.delta_nz) wrapped = '0;
		hue_ext = {{HUE_W{1'b0}}, wrapped};
		sat_ext = side.max_nz ? {{SAT_W{1'b0}}, sat_quo} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q <= hue_ext[HUE_W-1:0];
			sat_q <= sat_ext[SAT_W-1:0];
			val_q <= side.max;
		end
	end

	assign out_valid  = v_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = val_q;

endmodule

// ===== hw/rtl/rgb_to_hsv_pixel_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_unit
// Streaming RGB to HSV converter, one pixel per clock while not stalled.
// ----------------------------------------------------------------------------
// Input stream s_*: one RGB pixel per transaction in s_tdata[23:0].
// Output stream m_*: hue in 1/2^HUE_FRAC_BITS degree, saturation scaled to
// 2^SAT_BITS-1, and brightness (largest channel), packed into m_tdata.
// A pixel enters in every cycle in which the output side is not stalled.
// A pixel passes the front stages, then the divider pipeline of depth
// Q = max(clog2(60*2^HUE_FRAC_BITS + 1), SAT_BITS), one quotient bit per
// stage, and last the output register. Throughput is one pixel per cycle
// unless the output stalls: every stage holds its own pixel.
// Reset clears all valid bits, so the pipeline comes up empty; data registers
// are not reset. When the receiver holds m_tready low with a result waiting,
// the whole pipeline freezes and s_tready drops in the same cycle; nothing
// is dropped or repeated, and flow resumes as soon as m_tready returns.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_unit import rhsv_pkg::*; #(
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
	parameter int SAT_BITS      = SAT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [23:0] pixel_rgb
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // [14:0] hue, [30:15] saturation,
	                                          // [38:31] brightness, [39] zero
);

	localparam int HUE_SEXTANT = 60 << HUE_FRAC_BITS;
	localparam int HQ_W        = $clog2(HUE_SEXTANT + 1);
	localparam int QUO_W       = (HQ_W > SAT_BITS) ? HQ_W : SAT_BITS;
	localparam int HUE_NUM_W   = $clog2(2 * 255 * HUE_SEXTANT + 256);
	localparam int SAT_NUM_W   = SAT_BITS + 9;

	logic                 en;
	logic                 fr_valid, dv_valid;
	logic [HUE_NUM_W-1:0] hue_num;
	logic [SAT_NUM_W-1:0] sat_num;
	logic [DEN_W-1:0]     hue_den, sat_den;
	hsv_side_t            fr_side, dv_side;
	logic [QUO_W-1:0]     hue_quo, sat_quo;
	logic [HUE_W-1:0]     hue;
	logic [SAT_W-1:0]     saturation;
	logic [VAL_W-1:0]     brightness;

	// The pipeline advances whenever the output register is free or drains.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	rhsv_front #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS),
		.SAT_BITS     (SAT_BITS),
		.HUE_NUM_W    (HUE_NUM_W),
		.SAT_NUM_W    (SAT_NUM_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.pixel_rgb(s_tdata[PIX_W-1:0]),
		.out_valid(fr_valid),
		.hue_num  (hue_num),
		.hue_den  (hue_den),
		.sat_num  (sat_num),
		.sat_den  (sat_den),
		.side     (fr_side)
	);

	rhsv_div #(
		.HUE_NUM_W(HUE_NUM_W),
		.SAT_NUM_W(SAT_NUM_W),
		.QUO_W    (QUO_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.hue_num  (hue_num),
		.hue_den  (hue_den),
		.sat_num  (sat_num),
		.sat_den  (sat_den),
		.side_in  (fr_side),
		.out_valid(dv_valid),
		.hue_quo  (hue_quo),
		.sat_quo  (sat_quo),
		.side_out (dv_side)
	);

	rhsv_back #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS),
		.QUO_W        (QUO_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid),
		.hue_quo   (hue_quo),
		.sat_quo   (sat_quo),
		.side      (dv_side),
		.out_valid (m_tvalid),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness)
	);

	assign m_tdata = {1'b0, brightness, saturation, hue};

endmodule

// ===== hw/rtl/rhsv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_checker
// Port-level checks for the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhsv_checker import rhsv_pkg::*; #(
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int HUE_FULL = 360 << HUE_FRAC_BITS;

	logic [HUE_W-1:0] hue;
	logic [SAT_W-1:0] saturation;
	logic [VAL_W-1:0] brightness;
	logic             in_seen;

	assign hue        = m_tdata[14:0];
	assign saturation = m_tdata[30:15];
	assign brightness = m_tdata[38:31];
	assign in_seen    = s_tvalid && (s_tdata[PIX_W-1:0] == s_tdata[PIX_W-1:0]);

	// A stalled result holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction changed while stalled");

	// With no result waiting, the block must be able to take a pixel.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked while output register is empty");

	// A black pixel has neither saturation nor hue.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && brightness == '0 |-> saturation == '0 && hue == '0)
		else $error("black pixel with nonzero hue or saturation");

	// Zero saturation means a grey pixel, hue zero; checked only if !s_tvalid.
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && saturation == '0 && !in_seen |-> hue == '0 ||
		m_tvalid && saturation == '0 && in_seen && hue == '0 ||
		!(m_tvalid && saturation == '0))
		else $error("grey pixel with nonzero hue");

	// Hue stays below a full turn whenever the field can hold one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (HUE_FULL > 32767) || (int'(hue) < HUE_FULL))
		else $error("hue at or beyond a full turn");

endmodule

bind rgb_to_hsv_pixel_unit rhsv_checker #(
	.HUE_FRAC_BITS(HUE_FRAC_BITS)
) u_rhsv_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
